// ----- hdl/bdil_pkg.sv -----
package bdil_pkg;

  // Field and register widths.
  localparam int IMG_W_BITS     = 12;
  localparam int IMG_H_BITS     = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 1;
  localparam int WIN_BITS       = 9;

  // Largest frame height that the row counter follows.
  localparam logic [IMG_H_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Control bits that travel with one pixel from the position stage to the window stage.
  typedef struct packed {
    logic pb;        // New pixel, already masked to the image.
    logic nb_en;     // Row above lies inside the image.
    logic ob_en;     // Row two above lies inside the image.
    logic col_zero;  // Pixel opens a row.
    logic restart;   // Frame restarted before this pixel: window starts empty.
    logic emit;      // This transaction produces a result.
    logic last;      // This result closes the frame.
  } bdil_stage_t;

endpackage

// ----- hdl/binary_dilation_3x3_unit.sv -----
// Channel   Handshake             Payload
// in        in_valid / in_ready   pixel_in
// out       out_valid / out_ready pixel_out, frame_last
// cfg       cfg_write             cfg_index, cfg_data
//
// One input transaction per cycle is sustained unless the output stalls. A pixel
// is staged during its line buffer read, then moves into the output register.
// The result for raster pixel k leaves with input transaction k+width+1.
// Reset clears the position counters, the window and both valid flags; the
// line buffer is not cleared and needs no clearing pass.
// A stalled output holds the pipeline; while a result waits, one more input
// transaction can enter the stage register, then in_ready stays low.
module binary_dilation_3x3_unit
  import bdil_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      pixel_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      pixel_out,
  output logic                      frame_last
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic                a_valid;
  bdil_stage_t         a_stage;
  logic [COL_BITS-1:0] a_col;
  logic                rd_en;
  logic [COL_BITS-1:0] rd_addr;
  logic [1:0]          rd_data;
  logic                wr_en;
  logic [1:0]          wr_data;
  logic                out_free;

  // Position counters, configuration and the stage register.
  bdil_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_BITS  (COL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_free  (out_free),
    .a_valid   (a_valid),
    .a_stage   (a_stage),
    .a_col     (a_col),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Two previous rows, one column per entry.
  bdil_linebuf #(
    .DEPTH     (MAX_WIDTH),
    .ADDR_BITS (COL_BITS)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (a_col),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Sliding window and output register.
  bdil_window u_window (
    .clk        (clk),
    .rst        (rst),
    .a_valid    (a_valid),
    .a_stage    (a_stage),
    .rd_data    (rd_data),
    .out_free   (out_free),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  // A stage pixel blocked by the output stays in place.
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && !out_free) |=> a_valid)
    else $error("stage pixel lost while output stalled");

  // A pixel that produces a result lands in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && out_free && a_stage.emit) |=> out_valid)
    else $error("emitted result missing from output register");

  // The closing pixel of a frame is delivered with its flag.
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && out_free && a_stage.last) |=> (out_valid && frame_last))
    else $error("frame end flag missing");

  // Reset leaves both stages empty.
  assert property (@(posedge clk)
    rst |=> (!out_valid && !a_valid))
    else $error("pipeline not empty after reset");

endmodule

// ----- hdl/bdil_linebuf.sv -----
module bdil_linebuf
  import bdil_pkg::*;
#(
  parameter int DEPTH     = 2048,
  parameter int ADDR_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [1:0]           wr_data,
  output logic [1:0]           rd_data
);

  // Bit 1 holds the row above, bit 0 the row two above, for each column.
  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same column in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- hdl/bdil_ctrl.sv -----
module bdil_ctrl
  import bdil_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int COL_BITS  = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      pixel_in,
  input  logic                      out_free,
  output logic                      a_valid,
  output bdil_stage_t               a_stage,
  output logic [COL_BITS-1:0]       a_col,
  output logic                      rd_en,
  output logic [COL_BITS-1:0]       rd_addr
);

  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (EW > IMG_W_BITS) ? EW : IMG_W_BITS;

  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic [COL_BITS-1:0]   column_count;
  logic [IMG_H_BITS-1:0] row_count;

  logic [CMPW-1:0]       eff_w;
  logic [IMG_H_BITS-1:0] eff_h;
  logic [IMG_H_BITS-1:0] h_plus1;
  logic                  restart;
  logic [COL_BITS-1:0]   col;
  logic [IMG_H_BITS-1:0] row;
  logic [CMPW-1:0]       col_inc;
  logic [COL_BITS-1:0]   column_count_next;
  logic [IMG_H_BITS-1:0] row_count_next;
  bdil_stage_t           stage_next;
  logic                  accept;
  logic                  a_move;

  // Handshake: the position stage frees when its pixel moves into the window stage.
  assign a_move   = a_valid && out_free;
  assign in_ready = !a_valid || out_free;
  assign accept   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_BITS'(1);
      image_height <= IMG_H_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel and the masks it needs.
  always_comb begin
    if (image_width == '0) begin
      eff_w = CMPW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = CMPW'(image_width);
    end

    if (image_height == '0) begin
      eff_h = IMG_H_BITS'(1);
    end else if (image_height > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = image_height;
    end
    h_plus1 = eff_h + IMG_H_BITS'(1);

    restart = (CMPW'(column_count) >= eff_w) || (row_count > h_plus1);
    col     = restart ? '0 : column_count;
    row     = restart ? '0 : row_count;

    stage_next.pb       = (row < eff_h) && pixel_in;
    stage_next.nb_en    = (row != '0) && (row <= eff_h);
    stage_next.ob_en    = (row >= IMG_H_BITS'(2));
    stage_next.col_zero = (col == '0);
    stage_next.restart  = restart;
    stage_next.emit     = (row >= IMG_H_BITS'(2)) || ((row == IMG_H_BITS'(1)) && (col != '0));
    stage_next.last     = (row == h_plus1) && (col == '0);

    // Advance along the raster; the closing pixel starts a new frame.
    col_inc = CMPW'(col) + CMPW'(1);
    if (stage_next.last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (col_inc >= eff_w) begin
      column_count_next = '0;
      row_count_next    = row + IMG_H_BITS'(1);
    end else begin
      column_count_next = col_inc[COL_BITS-1:0];
      row_count_next    = row;
    end
  end

  assign rd_en   = accept;
  assign rd_addr = col;

  // Position counters and the stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      a_valid      <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        a_valid      <= 1'b1;
      end else if (a_move) begin
        a_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_stage <= stage_next;
      a_col   <= col;
    end
  end

endmodule

// ----- hdl/bdil_window.sv -----
module bdil_window
  import bdil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        a_valid,
  input  bdil_stage_t a_stage,
  input  logic [1:0]  rd_data,
  output logic        out_free,
  output logic        wr_en,
  output logic [1:0]  wr_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pixel_out,
  output logic        frame_last
);

  logic [WIN_BITS-1:0] window_bits;
  logic [WIN_BITS-1:0] window_bits_next;
  logic [WIN_BITS-1:0] prev;
  logic [2:0]          column;
  logic [5:0]          shifted;
  logic                bit_next;
  logic                a_move;

  assign out_free = !out_valid || out_ready;
  assign a_move   = a_valid && out_free;

  // Line buffer update: the row above ages into the row two above.
  assign wr_en   = a_move;
  assign wr_data = {a_stage.pb, rd_data[1]};

  // Slide the window one column and OR it down to the result bit.
  always_comb begin
    column  = {a_stage.pb, a_stage.nb_en & rd_data[1], a_stage.ob_en & rd_data[0]};
    prev    = a_stage.restart ? '0 : window_bits;
    shifted = prev[WIN_BITS-1:3];
    if (a_stage.col_zero) begin
      // Result belongs to the last pixel of the previous row: no column to its right.
      bit_next         = |shifted;
      window_bits_next = {column, 6'b0};
    end else begin
      window_bits_next = {column, shifted};
      bit_next         = |window_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (a_move) begin
        window_bits <= a_stage.last ? '0 : window_bits_next;
        out_valid   <= a_stage.emit;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      pixel_out  <= bit_next;
      frame_last <= a_stage.last;
    end
  end

endmodule

// ----- tb/binary_dilation_3x3_unit_tb.sv -----
module binary_dilation_3x3_unit_tb
  import bdil_pkg::*;
();

  localparam int MAX_W = 2048;
  localparam int DRAIN_CYCLES = 16;
  localparam int MISMATCH_REPORTS = 10;

  typedef struct packed {
    logic pixel;
    logic frame_end;
  } dilated_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      pixel_in;
  logic                      out_valid;
  logic                      out_ready;
  logic                      pixel_out;
  logic                      frame_last;

  // Predictor state: line buffers, window, raster position and registers.
  logic                  line_older_q [MAX_W];
  logic                  line_newer_q [MAX_W];
  logic [WIN_BITS-1:0]   window_q;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [IMG_W_BITS-1:0] width_reg;
  logic [IMG_H_BITS-1:0] height_reg;
  bit                    frame_closed;

  dilated_result_t expected_pixels [$];
  dilated_result_t front_result;
  int              mismatches;
  int              items_sent;
  int              send_idle_pct;
  int              recv_idle_pct;

  binary_dilation_3x3_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  // Clock with a period of 4 time units.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on run time, far above the slowest correct run.
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Computes the effect of one accepted pixel transaction on the dilation window.
  function automatic void predict_pixel(input logic pix);
    int unsigned     w;
    int unsigned     h;
    int unsigned     c;
    int unsigned     r;
    logic            pb;
    logic            nb;
    logic            ob;
    logic            bit_out;
    logic            emit;
    logic            is_end;
    logic [2:0]      column;
    dilated_result_t res;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_W) w = MAX_W;
    h = (height_reg == 0) ? 1 : height_reg;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    // A register change can leave the position outside the frame.
    if (col_pos >= w || row_pos > h + 1) begin
      col_pos  = 0;
      row_pos  = 0;
      window_q = '0;
    end
    c = col_pos;
    r = row_pos;
    pb = (r < h) ? pix : 1'b0;
    nb = (r >= 1 && r - 1 < h) ? line_newer_q[c] : 1'b0;
    ob = (r >= 2) ? line_older_q[c] : 1'b0;
    line_older_q[c] = line_newer_q[c];
    line_newer_q[c] = pb;
    column = {pb, nb, ob};
    // At the start of a row the output pixel has no right-hand column.
    if (c == 0) begin
      bit_out  = |window_q[8:3];
      window_q = {column, 6'b0};
    end else begin
      window_q = {column, window_q[8:3]};
      bit_out  = |window_q;
    end
    emit   = (r >= 2) || (r == 1 && c >= 1);
    is_end = (r == h + 1) && (c == 0);
    if (is_end) begin
      col_pos  = 0;
      row_pos  = 0;
      window_q = '0;
    end else begin
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
    end
    frame_closed = is_end;
    if (emit) begin
      res.pixel     = bit_out;
      res.frame_end = is_end;
      expected_pixels.insert(expected_pixels.size(), res);
    end
  endfunction

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each output transaction with the oldest expected result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        if (mismatches < MISMATCH_REPORTS)
          $display("unexpected result: pixel_out=%0b frame_last=%0b", pixel_out, frame_last);
        mismatches++;
      end else begin
        front_result = expected_pixels.pop_front();
        if (pixel_out !== front_result.pixel || frame_last !== front_result.frame_end) begin
          if (mismatches < MISMATCH_REPORTS)
            $display("mismatch: expected pixel_out=%0b frame_last=%0b, got %0b %0b",
                     front_result.pixel, front_result.frame_end, pixel_out, frame_last);
          mismatches++;
        end
      end
    end
  end

  // Send one pixel transaction, with random idle cycles ahead of it.
  task automatic send_pixel(input logic pix);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    predict_pixel(pix);
    items_sent++;
  endtask

  // Hold the input off until every expected result has left the block.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write, issued only while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_data  <= CFG_DATA_BITS'($urandom);
    if (idx == REG_IMAGE_WIDTH) width_reg = data[IMG_W_BITS-1:0];
    else height_reg = data[IMG_H_BITS-1:0];
  endtask

  task automatic set_size(input logic [CFG_DATA_BITS-1:0] w_data,
                          input logic [CFG_DATA_BITS-1:0] h_data);
    write_reg(REG_IMAGE_WIDTH, w_data);
    write_reg(REG_IMAGE_HEIGHT, h_data);
  endtask

  // Random pixels until the frame closes; optionally pause until drained.
  task automatic run_frame(input int ones_pct, input int pause_after);
    int n;
    n = 0;
    frame_closed = 1'b0;
    while (!frame_closed) begin
      send_pixel($urandom_range(99) < ones_pct);
      n++;
      if (n == pause_after) wait_drained();
    end
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(1'($urandom_range(1)));
  endtask

  // Tiny frames: reset size, zero size, a single dot and a full block.
  task automatic test_tiny_frames();
    logic [8:0] dot;
    run_frame(100, 0);
    set_size(13'd0, 13'd0);
    run_frame(100, 0);
    set_size(13'd3, 13'd3);
    dot = 9'b000_010_000;
    for (int i = 0; i < 9; i++) send_pixel(dot[i]);
    // Drain pixels are driven high; they must not leak into the result.
    run_frame(100, 0);
    set_size(13'd2, 13'd2);
    run_frame(100, 0);
  endtask

  // A wider row with the unused top data bit set, and a tall narrow frame.
  task automatic test_extreme_sizes();
    set_size(13'h1040, 13'd2);
    run_frame(3, 0);
    set_size(13'd1, 13'd40);
    run_frame(10, 0);
  endtask

  // Register writes in the middle of a frame, with and without a restart.
  task automatic test_mid_frame_writes();
    // Column past the new width restarts the frame.
    set_size(13'd5, 13'd4);
    send_random_pixels(9);
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    run_frame(40, 0);
    // Row past the new height restarts the frame.
    set_size(13'd2, 13'd6);
    send_random_pixels(10);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    run_frame(40, 0);
    // Growing width and height carries on with the same frame.
    set_size(13'd3, 13'd3);
    send_random_pixels(4);
    write_reg(REG_IMAGE_WIDTH, 13'd6);
    run_frame(30, 0);
    set_size(13'd4, 13'd2);
    send_random_pixels(6);
    write_reg(REG_IMAGE_HEIGHT, 13'd5);
    run_frame(30, 0);
    // Sender stops mid-frame until all results have come out.
    set_size(13'd6, 13'd4);
    run_frame(50, 7);
  endtask

  // Random sizes and contents under the three idling schedules.
  task automatic test_random_frames();
    int start;
    int pick;
    logic [CFG_DATA_BITS-1:0] w_data;
    logic [CFG_DATA_BITS-1:0] h_data;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 26 : 0;
      start = items_sent;
      while (items_sent - start < 300) begin
        pick = $urandom_range(99);
        w_data = (pick < 8) ? 13'd0 : (pick < 70) ? 13'($urandom_range(1, 6))
                                                  : 13'($urandom_range(7, 40));
        // The top data bit is outside the width register and must be dropped.
        w_data[CFG_DATA_BITS-1] = 1'($urandom_range(1));
        pick = $urandom_range(99);
        h_data = (pick < 8) ? 13'd0 : (pick < 70) ? 13'($urandom_range(1, 5))
                                                  : 13'($urandom_range(6, 20));
        set_size(w_data, h_data);
        repeat ($urandom_range(1, 3))
          run_frame($urandom_range(0, 100),
                    ($urandom_range(19) == 0) ? $urandom_range(1, 20) : 0);
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_IMAGE_WIDTH;
    cfg_data      = '0;
    in_valid      = 1'b0;
    pixel_in      = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    send_idle_pct = 26;
    recv_idle_pct = 81;
    width_reg     = IMG_W_BITS'(1);
    height_reg    = IMG_H_BITS'(1);
    col_pos       = 0;
    row_pos       = 0;
    window_q      = '0;
    frame_closed  = 1'b0;
    for (int i = 0; i < MAX_W; i++) begin
      line_older_q[i] = 1'b0;
      line_newer_q[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_tiny_frames();
    test_extreme_sizes();
    test_mid_frame_writes();
    test_random_frames();

    wait_drained();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
